// ----- hw/rtl/ircfmt_pkg.sv -----
`timescale 1ns / 1ps

package ircfmt_pkg;

	localparam int MAX_LINE_DEF    = 512;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int TAB_STOP        = 8;

	localparam logic [7:0] CH_COLOR = 8'h03;
	localparam logic [7:0] CH_BOLD  = 8'h02;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_REV   = 8'h16;
	localparam logic [7:0] CH_UND   = 8'h1F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] COLOR_RESET = 8'hFF;

	localparam int A_BOLD = 0;
	localparam int A_REV  = 1;
	localparam int A_UND  = 2;
	localparam int A_FGV  = 3;
	localparam int A_BGV  = 4;

	// one parsed byte: a run of identical characters and an optional closing item
	typedef struct packed {
		logic [7:0] chr;
		logic [3:0] fg;
		logic [3:0] bg;
		logic [4:0] attr;
		logic [3:0] nrep;
		logic       close;
	} entry_t;

endpackage

// ----- hw/rtl/ircfmt_queue.sv -----
`timescale 1ns / 1ps

module ircfmt_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = ircfmt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty,
	output logic             full
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign empty     = (count_q == '0);
	assign full      = (count_q == (AW+1)'(DEPTH));
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("queue written while full");

endmodule

// ----- hw/rtl/ircfmt_front.sv -----
`timescale 1ns / 1ps

module ircfmt_front #(
	parameter int MAX_LINE = ircfmt_pkg::MAX_LINE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  text_byte,
	input  logic                        line_end,
	input  logic                        q_full,
	output logic                        push,
	output ircfmt_pkg::entry_t          push_entry,
	output logic [$clog2(MAX_LINE)-1:0] push_base
);
	import ircfmt_pkg::*;

	localparam int CW = $clog2(MAX_LINE);
	localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_LINE - 1);

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_FG1,
		PH_FG2,
		PH_COMMA,
		PH_BG1,
		PH_BG2
	} phase_t;

	phase_t        phase_q, phase_n;
	logic [4:0]    attr_q, attr_n;
	logic [7:0]    color_q, color_n;
	logic [6:0]    acc_q, acc_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          full_q;
	logic          ordinary;
	logic          dig;
	logic [3:0]    digit;
	logic [6:0]    acc_two;
	logic [3:0]    rem;
	logic [CW-1:0] room;
	logic [3:0]    nrep;
	logic [7:0]    chr;
	logic          accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign dig      = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign digit    = text_byte[3:0];
	assign acc_two  = 7'(acc_q * 7'd10 + 7'(digit));
	assign rem      = 4'(TAB_STOP) - 4'(cnt_q[2:0]);
	assign room     = CNT_LIMIT - cnt_q;

	always_comb begin
		phase_n  = phase_q;
		attr_n   = attr_q;
		color_n  = color_q;
		acc_n    = acc_q;
		ordinary = 1'b0;
		nrep     = 4'd0;
		chr      = text_byte;
		if (!full_q) begin
			unique case (phase_q)
				PH_FG1: begin
					if (dig) begin
						acc_n         = 7'(digit);
						color_n[7:4]  = digit;
						attr_n[A_FGV] = 1'b1;
						phase_n       = PH_FG2;
					end else begin
						attr_n[A_FGV] = 1'b0;
						attr_n[A_BGV] = 1'b0;
						phase_n       = PH_NORMAL;
						ordinary      = 1'b1;
					end
				end
				PH_FG2, PH_COMMA: begin
					if (dig && phase_q == PH_FG2) begin
						acc_n         = acc_two;
						color_n[7:4]  = acc_two[3:0];
						attr_n[A_FGV] = 1'b1;
						phase_n       = PH_COMMA;
					end else if (text_byte == CH_COMMA) begin
						phase_n = PH_BG1;
					end else begin
						phase_n  = PH_NORMAL;
						ordinary = 1'b1;
					end
				end
				PH_BG1: begin
					phase_n = PH_NORMAL;
					if (dig) begin
						acc_n         = 7'(digit);
						color_n[3:0]  = digit;
						attr_n[A_BGV] = 1'b1;
						phase_n       = PH_BG2;
					end else begin
						ordinary = 1'b1;
					end
				end
				PH_BG2: begin
					phase_n = PH_NORMAL;
					if (dig) begin
						acc_n         = acc_two;
						color_n[3:0]  = acc_two[3:0];
						attr_n[A_BGV] = 1'b1;
					end else begin
						ordinary = 1'b1;
					end
				end
				default: begin
					phase_n  = PH_NORMAL;
					ordinary = 1'b1;
				end
			endcase
			if (ordinary) begin
				unique case (text_byte)
					CH_TAB: begin
						chr  = CH_SPACE;
						nrep = (32'(room) < 32'(rem)) ? room[3:0] : rem;
					end
					CH_BOLD:  attr_n[A_BOLD] = !attr_n[A_BOLD];
					CH_REV:   attr_n[A_REV]  = !attr_n[A_REV];
					CH_UND:   attr_n[A_UND]  = !attr_n[A_UND];
					CH_COLOR: phase_n = PH_FG1;
					default: begin
						if (text_byte >= CH_SPACE) begin
							nrep = 4'd1;
						end
					end
				endcase
			end
		end
		cnt_n = cnt_q + CW'(nrep);
	end

	assign push             = accept && (nrep != 4'd0 || line_end);
	assign push_base        = cnt_q;
	assign push_entry.chr   = chr;
	assign push_entry.fg    = color_n[7:4];
	assign push_entry.bg    = color_n[3:0];
	assign push_entry.attr  = attr_n;
	assign push_entry.nrep  = nrep;
	assign push_entry.close = line_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			attr_q  <= '0;
			color_q <= COLOR_RESET;
			acc_q   <= '0;
			cnt_q   <= '0;
			full_q  <= 1'b0;
		end else if (accept) begin
			if (line_end) begin
				phase_q <= PH_NORMAL;
				attr_q  <= '0;
				color_q <= COLOR_RESET;
				acc_q   <= '0;
				cnt_q   <= '0;
				full_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				attr_q  <= attr_n;
				color_q <= color_n;
				acc_q   <= acc_n;
				cnt_q   <= cnt_n;
				full_q  <= (cnt_n >= CNT_LIMIT);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LIMIT)
		else $error("character count beyond line limit");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		full_q == (cnt_q == CNT_LIMIT))
		else $error("line full flag out of step with count");

endmodule

// ----- hw/rtl/ircfmt_back.sv -----
`timescale 1ns / 1ps

module ircfmt_back #(
	parameter int MAX_LINE = ircfmt_pkg::MAX_LINE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  ircfmt_pkg::entry_t          head,
	input  logic [$clog2(MAX_LINE)-1:0] head_base,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  char_code,
	output logic [3:0]                  fg_color,
	output logic [3:0]                  bg_color,
	output logic                        bold_on,
	output logic                        reverse_on,
	output logic                        underline_on,
	output logic                        fg_valid,
	output logic                        bg_valid,
	output logic                        closing_item,
	output logic [8:0]                  chars_in_line
);
	import ircfmt_pkg::*;

	localparam int CW = $clog2(MAX_LINE);

	logic [3:0]    idx_q;
	logic          valid_q;
	logic [7:0]    chr_q;
	logic [3:0]    fg_q;
	logic [3:0]    bg_q;
	logic [4:0]    attr_q;
	logic          close_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   cnt_wide;
	logic          adv;
	logic          more_chars;
	logic          last_char;

	assign adv        = !q_empty && (!valid_q || out_ready);
	assign more_chars = (idx_q < head.nrep);
	assign last_char  = (idx_q + 4'd1 == head.nrep);
	assign pop        = adv && (more_chars ? (last_char && !head.close) : 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (!valid_q || out_ready) begin
				valid_q <= !q_empty;
			end
			if (adv) begin
				idx_q <= (pop || !more_chars) ? 4'd0 : idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (more_chars) begin
				chr_q   <= head.chr;
				fg_q    <= head.fg;
				bg_q    <= head.bg;
				attr_q  <= head.attr;
				close_q <= 1'b0;
				cnt_q   <= head_base + CW'(idx_q) + CW'(1);
			end else begin
				chr_q   <= '0;
				fg_q    <= '0;
				bg_q    <= '0;
				attr_q  <= '0;
				close_q <= 1'b1;
				cnt_q   <= head_base + CW'(head.nrep);
			end
		end
	end

	assign cnt_wide      = 32'(cnt_q);
	assign out_valid     = valid_q;
	assign char_code     = chr_q;
	assign fg_color      = fg_q;
	assign bg_color      = bg_q;
	assign bold_on       = attr_q[A_BOLD];
	assign reverse_on    = attr_q[A_REV];
	assign underline_on  = attr_q[A_UND];
	assign fg_valid      = attr_q[A_FGV];
	assign bg_valid      = attr_q[A_BGV];
	assign closing_item  = close_q;
	assign chars_in_line = cnt_wide[8:0];

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> idx_q <= head.nrep)
		else $error("run index past run length");

endmodule

// ----- hw/rtl/irc_format_code_parser.sv -----
`timescale 1ns / 1ps

// irc formatting code parser
// input channel: one raw byte of a text line per transfer (text_byte),
// line_end marks the last byte of the line
// output channel: one visible character per transfer with its colour nibbles
// and attribute bits; after the last byte of a line a closing item follows
// with closing_item set and chars_in_line holding the line length
// the front parses one byte per cycle while in_ready is high and writes a
// run descriptor into a small queue; the back expands each run, one result
// per cycle while the receiver takes them; a byte's first result is held in
// the queue and then in the output register before out_valid rises
// throughput: one byte per cycle for plain text; a tab yields up to eight
// spaces and occupies the back for one result per space, and the queue
// absorbs the difference until it fills and in_ready drops
// when the receiver stalls, the output register holds its item and the
// queue fills; bytes that produce nothing still pass while it has room
// reset clears attributes, colours (to 0xff), the count and both sides
// of the queue; the block is ready for a byte as soon as reset ends
module irc_format_code_parser #(
	parameter int MAX_LINE    = ircfmt_pkg::MAX_LINE_DEF,
	parameter int QUEUE_DEPTH = ircfmt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_code,
	output logic [3:0] fg_color,
	output logic [3:0] bg_color,
	output logic       bold_on,
	output logic       reverse_on,
	output logic       underline_on,
	output logic       fg_valid,
	output logic       bg_valid,
	output logic       closing_item,
	output logic [8:0] chars_in_line
);
	import ircfmt_pkg::*;

	localparam int CW = $clog2(MAX_LINE);
	localparam int QW = $bits(entry_t) + CW;

	logic          push;
	logic          pop;
	logic          q_empty;
	logic          q_full;
	entry_t        push_entry;
	logic [CW-1:0] push_base;
	entry_t        head;
	logic [CW-1:0] head_base;
	logic [QW-1:0] head_data;

	ircfmt_front #(
		.MAX_LINE(MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.line_end  (line_end),
		.q_full    (q_full),
		.push      (push),
		.push_entry(push_entry),
		.push_base (push_base)
	);

	ircfmt_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_entry, push_base}),
		.pop      (pop),
		.head_data(head_data),
		.empty    (q_empty),
		.full     (q_full)
	);

	assign head      = entry_t'(head_data[QW-1:CW]);
	assign head_base = head_data[CW-1:0];

	ircfmt_back #(
		.MAX_LINE(MAX_LINE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.head         (head),
		.head_base    (head_base),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.fg_color     (fg_color),
		.bg_color     (bg_color),
		.bold_on      (bold_on),
		.reverse_on   (reverse_on),
		.underline_on (underline_on),
		.fg_valid     (fg_valid),
		.bg_valid     (bg_valid),
		.closing_item (closing_item),
		.chars_in_line(chars_in_line)
	);

endmodule

// ----- bench/tb_irc_format_code_parser.sv -----
`timescale 1ns / 1ps

module tb_irc_format_code_parser;
	import ircfmt_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} raw_byte_t;

	typedef struct packed {
		logic [7:0] chr;
		logic [3:0] fg;
		logic [3:0] bg;
		logic       bold;
		logic       rev;
		logic       und;
		logic       fgv;
		logic       bgv;
		logic       close;
		logic [8:0] len;
	} glyph_t;

	typedef enum logic [2:0] {
		PH_TEXT,
		PH_FG_FIRST,
		PH_FG_SECOND,
		PH_AFTER_FG,
		PH_BG_FIRST,
		PH_BG_SECOND
	} parse_phase_e;

	localparam int LINE_LIMIT = MAX_LINE_DEF - 1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte = '0;
	logic       line_end = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] char_code;
	logic [3:0] fg_color;
	logic [3:0] bg_color;
	logic       bold_on;
	logic       reverse_on;
	logic       underline_on;
	logic       fg_valid;
	logic       bg_valid;
	logic       closing_item;
	logic [8:0] chars_in_line;

	raw_byte_t byte_feed[$];
	glyph_t    glyphs_due[$];

	// predictor state
	logic [4:0]   attr;
	logic [7:0]   palette;
	parse_phase_e phase;
	logic [6:0]   color_acc;
	int           text_count;
	logic         line_full;

	int error_count = 0;
	int bytes_taken = 0;
	int results_seen = 0;
	int lines_closed = 0;
	int full_lines = 0;
	int burst_left = 1;
	int gap_left = 0;
	int hold_left = 0;
	int next_hold_at = 150;
	int mode_cycle = 0;
	int stall_mode = 0;

	irc_format_code_parser i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.line_end     (line_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.fg_color     (fg_color),
		.bg_color     (bg_color),
		.bold_on      (bold_on),
		.reverse_on   (reverse_on),
		.underline_on (underline_on),
		.fg_valid     (fg_valid),
		.bg_valid     (bg_valid),
		.closing_item (closing_item),
		.chars_in_line(chars_in_line)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 40) begin
			$display("mismatch at %0t ns: %s", $time, what);
		end
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("result %0d %s got %0h want %0h",
				results_seen, name, got, want));
		end
	endtask

	function automatic void clear_line();
		attr = '0;
		palette = COLOR_RESET;
		phase = PH_TEXT;
		color_acc = '0;
		text_count = 0;
		line_full = 1'b0;
	endfunction

	function automatic void emit_glyph(input logic [7:0] chr);
		glyph_t g;
		text_count++;
		g.chr = chr;
		g.fg = palette[7:4];
		g.bg = palette[3:0];
		g.bold = attr[A_BOLD];
		g.rev = attr[A_REV];
		g.und = attr[A_UND];
		g.fgv = attr[A_FGV];
		g.bgv = attr[A_BGV];
		g.close = 1'b0;
		g.len = text_count[8:0];
		glyphs_due.push_back(g);
		if (text_count >= LINE_LIMIT && !line_full) begin
			line_full = 1'b1;
			full_lines++;
		end
	endfunction

	function automatic void plain_byte(input logic [7:0] c);
		if (c == CH_TAB) begin
			emit_glyph(CH_SPACE);
			while ((text_count % TAB_STOP) != 0 && !line_full) begin
				emit_glyph(CH_SPACE);
			end
		end else if (c == CH_BOLD) begin
			attr[A_BOLD] = ~attr[A_BOLD];
		end else if (c == CH_REV) begin
			attr[A_REV] = ~attr[A_REV];
		end else if (c == CH_UND) begin
			attr[A_UND] = ~attr[A_UND];
		end else if (c == CH_COLOR) begin
			phase = PH_FG_FIRST;
		end else if (c >= CH_SPACE) begin
			emit_glyph(c);
		end
	endfunction

	function automatic void parse_byte(input logic [7:0] c, input logic last);
		logic   is_dig;
		int     d;
		logic   ordinary;
		glyph_t g;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		d = int'(c) - int'(CH_ZERO);
		ordinary = 1'b0;
		if (!line_full) begin
			case (phase)
				PH_FG_FIRST: begin
					if (is_dig) begin
						color_acc = 7'(d);
						palette[7:4] = color_acc[3:0];
						attr[A_FGV] = 1'b1;
						phase = PH_FG_SECOND;
					end else begin
						attr[A_FGV] = 1'b0;
						attr[A_BGV] = 1'b0;
						phase = PH_TEXT;
						ordinary = 1'b1;
					end
				end
				PH_FG_SECOND, PH_AFTER_FG: begin
					if (is_dig && phase == PH_FG_SECOND) begin
						color_acc = 7'(int'(color_acc) * 10 + d);
						palette[7:4] = color_acc[3:0];
						attr[A_FGV] = 1'b1;
						phase = PH_AFTER_FG;
					end else if (c == CH_COMMA) begin
						phase = PH_BG_FIRST;
					end else begin
						phase = PH_TEXT;
						ordinary = 1'b1;
					end
				end
				PH_BG_FIRST: begin
					phase = PH_TEXT;
					if (is_dig) begin
						color_acc = 7'(d);
						palette[3:0] = color_acc[3:0];
						attr[A_BGV] = 1'b1;
						phase = PH_BG_SECOND;
					end else begin
						ordinary = 1'b1;
					end
				end
				PH_BG_SECOND: begin
					phase = PH_TEXT;
					if (is_dig) begin
						color_acc = 7'(int'(color_acc) * 10 + d);
						palette[3:0] = color_acc[3:0];
						attr[A_BGV] = 1'b1;
					end else begin
						ordinary = 1'b1;
					end
				end
				default: begin
					phase = PH_TEXT;
					ordinary = 1'b1;
				end
			endcase
			if (ordinary) begin
				plain_byte(c);
			end
		end
		if (last) begin
			g = '0;
			g.close = 1'b1;
			g.len = text_count[8:0];
			glyphs_due.push_back(g);
			lines_closed++;
			clear_line();
		end
	endfunction

	function automatic void push_byte(input logic [7:0] data, input logic last);
		raw_byte_t r;
		r.data = data;
		r.last = last;
		byte_feed.push_back(r);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// sender: bursts and gaps, predicts on every accepted transfer
	always @(posedge clk) begin : feed_driver
		raw_byte_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				parse_byte(text_byte, line_end);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (byte_feed.size() > 0) begin
					nxt = byte_feed.pop_front();
					in_valid <= 1'b1;
					text_byte <= nxt.data;
					line_end <= nxt.last;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: rotating stall patterns plus long hold-offs
	always @(posedge clk) begin
		mode_cycle <= mode_cycle + 1;
		if (mode_cycle % 64 == 63) begin
			stall_mode <= $urandom_range(0, 3);
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (results_seen >= next_hold_at) begin
			hold_left <= 100;
			next_hold_at <= next_hold_at + 1500;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (mode_cycle % 3 != 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_monitor
		glyph_t want;
		if (arst_n && out_valid && out_ready) begin
			if (glyphs_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result char %0h closing %0b",
					char_code, closing_item));
			end else begin
				want = glyphs_due.pop_front();
				check_field("char_code", char_code, want.chr);
				check_field("fg_color", fg_color, want.fg);
				check_field("bg_color", bg_color, want.bg);
				check_field("bold_on", bold_on, want.bold);
				check_field("reverse_on", reverse_on, want.rev);
				check_field("underline_on", underline_on, want.und);
				check_field("fg_valid", fg_valid, want.fgv);
				check_field("bg_valid", bg_valid, want.bgv);
				check_field("closing_item", closing_item, want.close);
				check_field("chars_in_line", chars_in_line, want.len);
			end
			results_seen++;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2ms;
		$display("timeout with %0d results still due", glyphs_due.size());
		$display("[irc_format_code_parser] ERROR");
		$finish;
	end

	initial begin : stimulus
		int line_no;
		int segs;
		int n;
		raw_byte_t tail;
		clear_line();

		// attribute toggles
		push_byte(CH_BOLD, 1'b0);
		push_byte(CH_REV, 1'b0);
		push_byte(CH_UND, 1'b0);
		push_byte("A", 1'b1);
		// two-digit colours, one above 15, then foreground with a bare comma
		push_byte(CH_COLOR, 1'b0);
		push_byte("9", 1'b0);
		push_byte("9", 1'b0);
		push_byte(CH_COMMA, 1'b0);
		push_byte("1", 1'b0);
		push_byte("5", 1'b0);
		push_byte("y", 1'b0);
		push_byte(CH_COLOR, 1'b0);
		push_byte("4", 1'b0);
		push_byte(CH_COMMA, 1'b0);
		push_byte("z", 1'b1);
		// colour code with no digit, zero byte, high byte, tab
		push_byte(CH_COLOR, 1'b0);
		push_byte("q", 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(CH_TAB, 1'b1);
		// line ends inside a colour sequence
		push_byte(CH_COLOR, 1'b0);
		push_byte("5", 1'b0);
		push_byte(CH_COMMA, 1'b1);
		// empty line with a dropped control byte
		push_byte(8'h1B, 1'b1);

		line_no = 0;
		while (byte_feed.size() < 24 + 380) begin
			line_no++;
			if (line_no == 6 || line_no == 30) begin
				// tabs run the line into its limit, then codes that must be ignored
				for (int k = 0; k < 66; k++) begin
					if ($urandom_range(0, 7) == 0) begin
						push_byte(8'($urandom_range(0, 255)), 1'b0);
					end
					push_byte(CH_TAB, 1'b0);
				end
				push_byte(CH_BOLD, 1'b0);
				push_byte(CH_COLOR, 1'b0);
				push_byte("3", 1'b0);
				push_byte("x", 1'b0);
			end else begin
				segs = $urandom_range(1, 8);
				for (int s = 0; s < segs; s++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: begin
							n = $urandom_range(1, 5);
							for (int k = 0; k < n; k++) begin
								push_byte(8'($urandom_range(32, 255)), 1'b0);
							end
						end
						4: begin
							case ($urandom_range(0, 2))
								0: push_byte(CH_BOLD, 1'b0);
								1: push_byte(CH_REV, 1'b0);
								default: push_byte(CH_UND, 1'b0);
							endcase
						end
						5, 6: begin
							push_byte(CH_COLOR, 1'b0);
							n = $urandom_range(0, 2);
							for (int k = 0; k < n; k++) begin
								push_byte(rand_digit(), 1'b0);
							end
							if ($urandom_range(0, 1) == 1) begin
								push_byte(CH_COMMA, 1'b0);
								n = $urandom_range(0, 2);
								for (int k = 0; k < n; k++) begin
									push_byte(rand_digit(), 1'b0);
								end
							end
						end
						7: push_byte(CH_TAB, 1'b0);
						default: push_byte(8'($urandom_range(0, 255)), 1'b0);
					endcase
				end
			end
			tail = byte_feed.pop_back();
			tail.last = 1'b1;
			byte_feed.push_back(tail);
		end

		while (byte_feed.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (glyphs_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);

		$display("fed %0d bytes over %0d lines, %0d of them filled to the limit",
			bytes_taken, lines_closed, full_lines);
		$display("checked %0d results, %0d mismatches", results_seen, error_count);
		if (error_count == 0) begin
			$display("[irc_format_code_parser] OK");
		end else begin
			$display("[irc_format_code_parser] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/ircfmt_pkg.sv
hw/rtl/ircfmt_queue.sv
hw/rtl/ircfmt_front.sv
hw/rtl/ircfmt_back.sv
hw/rtl/irc_format_code_parser.sv
bench/tb_irc_format_code_parser.sv
